### design/vibration_baseline_anomaly_monitor_defines.svh
// Assertion macros for the vibration baseline anomaly monitor.
// Taken in by the checker; needs nothing else.
`ifndef VIBRATION_BASELINE_ANOMALY_MONITOR_DEFINES_SVH
`define VIBRATION_BASELINE_ANOMALY_MONITOR_DEFINES_SVH

// same-cycle implication
`define VBAM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VBAM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/vbam_pkg.sv
// Shared types and constants of the vibration baseline anomaly monitor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vbam_pkg;

    typedef enum logic [2:0] {
        MODE_INIT     = 3'd0,
        MODE_WARMUP   = 3'd1,
        MODE_HEALTHY  = 3'd2,
        MODE_ALARM    = 3'd3,
        MODE_NO_MOTOR = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_DECIDE,
        PH_W_BEGIN,
        PH_W_ISSUE,
        PH_W_WAIT,
        PH_W_MUL,
        PH_W_ACC,
        PH_W_CHECK,
        PH_B_ISSUE,
        PH_B_DWAIT,
        PH_B_SWAIT,
        PH_B_NEXT,
        PH_B_END,
        PH_M_ISSUE,
        PH_M_WAIT,
        PH_M_END
    } phase_t;

    typedef enum logic [2:0] {
        CFG_WARMUP_TARGET = 3'd0,
        CFG_MIN_VALID     = 3'd1,
        CFG_SCORE_THRESH  = 3'd2,
        CFG_MEAN_MARGIN   = 3'd3,
        CFG_ALARM_RUN     = 3'd4,
        CFG_HEALTHY_RUN   = 3'd5,
        CFG_SILENT_RUN    = 3'd6
    } cfg_idx_t;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef struct packed {
        logic        action;
        logic        peak_seen;
        logic [31:0] rms_level;
        logic [31:0] kurtosis_level;
        logic [31:0] harmonic_amplitude;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         machine_state;
        logic [15:0]        warmup_progress;
        logic signed [23:0] rms_score;
        logic signed [23:0] kurtosis_score;
        logic signed [23:0] harmonic_score;
        logic               rms_flag;
        logic               kurtosis_flag;
        logic               harmonic_flag;
    } out_item_t;

    localparam int CFG_DATA_W = 23;

    localparam logic [15:0] RST_WARMUP_TARGET = 16'd600;
    localparam logic [15:0] RST_MIN_VALID     = 16'd100;
    localparam logic [22:0] RST_SCORE_THRESH  = 23'd196608;
    localparam logic [15:0] RST_MEAN_MARGIN   = 16'd13107;
    localparam logic [7:0]  RST_ALARM_RUN     = 8'd5;
    localparam logic [7:0]  RST_HEALTHY_RUN   = 8'd5;
    localparam logic [7:0]  RST_SILENT_RUN    = 8'd15;

    localparam logic [5:0]  DIV_LAST_STEP  = 6'd63;
    localparam logic [5:0]  SQRT_LAST_STEP = 6'd31;

    localparam logic [23:0] SCORE_MAX = 24'h7FFFFF;
    localparam logic [23:0] SCORE_MIN = 24'h800000;

endpackage

`default_nettype wire

### design/vbam_arith.sv
// Shared bit-serial unit: 64/32 restoring divide (64 steps) and
// 64-bit floor square root (32 steps). Depends on vbam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vbam_arith (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire vbam_pkg::arith_req_t req,
    input  wire  [63:0]               opa,
    input  wire  [31:0]               opb,
    output logic                      done,
    output logic [63:0]               res
);

    logic                busy_reg;
    vbam_pkg::arith_op_t op_reg;
    logic [5:0]          cnt_reg;
    logic [63:0]         shf_reg;
    logic [32:0]         rem_reg;
    logic [31:0]         root_reg;
    logic [31:0]         dvs_reg;
    logic                done_reg;
    logic [63:0]         res_reg;

    logic [32:0] div_rem_s;
    logic        div_ge;
    logic [32:0] div_rem_n;
    logic [34:0] sq_rem_s;
    logic [34:0] sq_trial;
    logic        sq_ge;
    logic [34:0] sq_rem_n;
    logic        last_step;

    always_comb begin
        div_rem_s = {rem_reg[31:0], shf_reg[63]};
        div_ge    = div_rem_s >= {1'b0, dvs_reg};
        div_rem_n = div_ge ? div_rem_s - {1'b0, dvs_reg} : div_rem_s;
        sq_rem_s  = {rem_reg, shf_reg[63:62]};
        sq_trial  = {1'b0, root_reg, 2'b01};
        sq_ge     = sq_rem_s >= sq_trial;
        sq_rem_n  = sq_ge ? sq_rem_s - sq_trial : sq_rem_s;
        last_step = (op_reg == vbam_pkg::OP_DIV) ? (cnt_reg == vbam_pkg::DIV_LAST_STEP)
                                                 : (cnt_reg == vbam_pkg::SQRT_LAST_STEP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= '0;
                shf_reg  <= opa;
                dvs_reg  <= opb;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (op_reg == vbam_pkg::OP_DIV) begin
                    rem_reg <= div_rem_n;
                    shf_reg <= {shf_reg[62:0], div_ge};
                    if (last_step) begin
                        res_reg <= {shf_reg[62:0], div_ge};
                    end
                end else begin
                    rem_reg  <= sq_rem_n[32:0];
                    root_reg <= {root_reg[30:0], sq_ge};
                    shf_reg  <= {shf_reg[61:0], 2'b00};
                    if (last_step) begin
                        res_reg <= {32'd0, root_reg[30:0], sq_ge};
                    end
                end
                if (last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

### design/vibration_baseline_anomaly_monitor.sv
// Top level of the vibration baseline anomaly monitor: sequencer, state and
// configuration registers. Depends on vbam_pkg and vbam_arith.
//
// One request is taken at a time; s_ready is high only while the sequencer
// is idle, and a finished result waits in an output register so the next
// request can be taken before it is read; while an earlier result is still
// unread, the sequencer holds before publishing the new one. Cost per request
// is set by the shared bit-serial divide/square-root unit, walked over the
// three features one after another: a restart or no-motor request does not
// use the unit, a warm-up request takes one divide per feature, a monitoring
// request one divide per feature, and the warm-up request that closes the
// baseline adds a variance divide and square root per feature.
`timescale 1ns / 1ps
`default_nettype none

module vibration_baseline_anomaly_monitor (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_wr_en,
    input  wire  [2:0]                      cfg_index,
    input  wire  [vbam_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire vbam_pkg::in_item_t         s_data,
    output logic                            m_valid,
    input  wire                             m_ready,
    output vbam_pkg::out_item_t             m_data
);

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

    // configuration
    logic [15:0] warmup_target_reg, min_valid_reg, mean_margin_reg;
    logic [22:0] score_thresh_reg;
    logic [7:0]  alarm_run_reg, healthy_run_reg, silent_run_reg;

    // sequencer and item
    vbam_pkg::phase_t ph_reg, ph_next;
    logic [31:0] x_reg [3];
    logic        pv_reg, act_reg;
    logic [1:0]  k_reg, k_next;
    logic        ok_reg, ok_next;
    logic        sign_reg, sign_next;
    logic [31:0] a_reg, a_next, b_reg, b_next;
    logic [63:0] mul_reg, mul_next;
    logic [31:0] mul_a, mul_b;

    // block state
    vbam_pkg::mode_t mode_reg, mode_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] mean_reg [3];
    logic [31:0] mean_next [3];
    logic [63:0] m2_reg [3];
    logic [63:0] m2_next [3];
    logic [31:0] bmean_reg [3];
    logic [31:0] bmean_next [3];
    logic [31:0] spread_reg [3];
    logic [31:0] spread_next [3];
    logic        bok_reg, bok_next;
    logic [7:0]  ab_reg, ab_next, no_reg, no_next, sil_reg, sil_next;
    logic [23:0] score_reg [3];
    logic [23:0] score_next [3];
    logic [2:0]  flags_reg, flags_next;

    // output
    logic                m_valid_reg, m_valid_next;
    vbam_pkg::out_item_t out_reg, out_next;

    // shared unit
    vbam_pkg::arith_req_t ar_req;
    logic [63:0] ar_a, ar_res;
    logic [31:0] ar_b;
    logic        ar_done;

    logic [32:0] d33;
    logic [7:0]  sil_upd;
    logic [64:0] m2_sum;
    logic [63:0] qa;
    logic        ov_mean, ov_z, abn, out_load;
    logic [7:0]  ab_inc, no_inc;

    vbam_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ar_req),
        .opa     (ar_a),
        .opb     (ar_b),
        .done    (ar_done),
        .res     (ar_res)
    );

    always_comb begin
        ph_next      = ph_reg;
        k_next       = k_reg;
        ok_next      = ok_reg;
        sign_next    = sign_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        mul_next     = mul_reg;
        mul_a        = a_reg;
        mul_b        = b_reg;
        mode_next    = mode_reg;
        count_next   = count_reg;
        mean_next    = mean_reg;
        m2_next      = m2_reg;
        bmean_next   = bmean_reg;
        spread_next  = spread_reg;
        bok_next     = bok_reg;
        ab_next      = ab_reg;
        no_next      = no_reg;
        sil_next     = sil_reg;
        score_next   = score_reg;
        flags_next   = flags_reg;
        ar_req.start = 1'b0;
        ar_req.op    = vbam_pkg::OP_DIV;
        ar_a         = '0;
        ar_b         = '0;
        out_load     = 1'b0;
        s_ready      = 1'b0;

        d33     = {1'b0, x_reg[k_reg]} - {1'b0, mean_reg[k_reg]};
        sil_upd = pv_reg ? 8'd0 : sat_inc(sil_reg);
        m2_sum  = {1'b0, m2_reg[k_reg]} + {1'b0, mul_reg};
        qa      = ar_res;
        ov_mean = {16'd0, x_reg[k_reg], 16'd0} > mul_reg;
        ov_z    = !sign_reg && (qa > {41'd0, score_thresh_reg});
        abn     = (flags_reg[0] & flags_reg[1]) | (flags_reg[0] & flags_reg[2])
                | (flags_reg[1] & flags_reg[2]);
        ab_inc  = sat_inc(ab_reg);
        no_inc  = sat_inc(no_reg);

        case (ph_reg)
            vbam_pkg::PH_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ph_next = vbam_pkg::PH_DECIDE;
                end
            end
            vbam_pkg::PH_DECIDE: begin
                ph_next = vbam_pkg::PH_M_END;
                if (act_reg) begin
                    mode_next   = vbam_pkg::MODE_INIT;
                    count_next  = '0;
                    mean_next   = '{default: '0};
                    m2_next     = '{default: '0};
                    bmean_next  = '{default: '0};
                    spread_next = '{default: '0};
                    bok_next    = 1'b0;
                    score_next  = '{default: '0};
                    flags_next  = '0;
                    ab_next     = '0;
                    no_next     = '0;
                end else if (mode_reg == vbam_pkg::MODE_NO_MOTOR) begin
                    if (pv_reg) begin
                        sil_next = '0;
                        ab_next  = '0;
                        no_next  = '0;
                        if (bok_reg) begin
                            mode_next  = vbam_pkg::MODE_HEALTHY;
                            score_next = '{default: '0};
                            flags_next = '0;
                            k_next     = '0;
                            ph_next    = vbam_pkg::PH_M_ISSUE;
                        end else begin
                            mode_next  = vbam_pkg::MODE_WARMUP;
                            count_next = '0;
                            mean_next  = '{default: '0};
                            m2_next    = '{default: '0};
                            ph_next    = vbam_pkg::PH_W_BEGIN;
                        end
                    end
                end else if (!pv_reg && sil_upd >= silent_run_reg) begin
                    mode_next  = vbam_pkg::MODE_NO_MOTOR;
                    count_next = '0;
                    mean_next  = '{default: '0};
                    m2_next    = '{default: '0};
                    score_next = '{default: '0};
                    flags_next = '0;
                    ab_next    = '0;
                    no_next    = '0;
                    sil_next   = silent_run_reg;
                end else begin
                    sil_next = sil_upd;
                    case (mode_reg)
                        vbam_pkg::MODE_INIT, vbam_pkg::MODE_WARMUP: begin
                            mode_next = vbam_pkg::MODE_WARMUP;
                            if (pv_reg) begin
                                ph_next = vbam_pkg::PH_W_BEGIN;
                            end
                        end
                        vbam_pkg::MODE_HEALTHY, vbam_pkg::MODE_ALARM: begin
                            if (bok_reg) begin
                                score_next = '{default: '0};
                                flags_next = '0;
                                k_next     = '0;
                                ph_next    = vbam_pkg::PH_M_ISSUE;
                            end
                        end
                        default: begin
                            mode_next   = vbam_pkg::MODE_INIT;
                            count_next  = '0;
                            mean_next   = '{default: '0};
                            m2_next     = '{default: '0};
                            bmean_next  = '{default: '0};
                            spread_next = '{default: '0};
                            bok_next    = 1'b0;
                            score_next  = '{default: '0};
                            flags_next  = '0;
                            ab_next     = '0;
                            no_next     = '0;
                        end
                    endcase
                end
            end
            vbam_pkg::PH_W_BEGIN: begin
                count_next = (count_reg == 16'hFFFF) ? 16'hFFFF : count_reg + 16'd1;
                k_next     = '0;
                ph_next    = vbam_pkg::PH_W_ISSUE;
            end
            vbam_pkg::PH_W_ISSUE: begin
                sign_next    = d33[32];
                a_next       = d33[32] ? 32'(-d33) : d33[31:0];
                ar_req.start = 1'b1;
                ar_req.op    = vbam_pkg::OP_DIV;
                ar_a         = {32'd0, a_next};
                ar_b         = {16'd0, count_reg};
                ph_next      = vbam_pkg::PH_W_WAIT;
            end
            vbam_pkg::PH_W_WAIT: begin
                if (ar_done) begin
                    mean_next[k_reg] = sign_reg ? mean_reg[k_reg] - qa[31:0]
                                                : mean_reg[k_reg] + qa[31:0];
                    b_next  = a_reg - qa[31:0];
                    ph_next = vbam_pkg::PH_W_MUL;
                end
            end
            vbam_pkg::PH_W_MUL: begin
                mul_next = {32'd0, mul_a} * {32'd0, mul_b};
                ph_next  = vbam_pkg::PH_W_ACC;
            end
            vbam_pkg::PH_W_ACC: begin
                m2_next[k_reg] = m2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum[63:0];
                if (k_reg == 2'd2) begin
                    ph_next = vbam_pkg::PH_W_CHECK;
                end else begin
                    k_next  = k_reg + 2'd1;
                    ph_next = vbam_pkg::PH_W_ISSUE;
                end
            end
            vbam_pkg::PH_W_CHECK: begin
                if (count_reg < warmup_target_reg) begin
                    ph_next = vbam_pkg::PH_M_END;
                end else begin
                    ok_next = (count_reg >= 16'd2) && (count_reg >= min_valid_reg);
                    k_next  = '0;
                    ph_next = vbam_pkg::PH_B_ISSUE;
                end
            end
            vbam_pkg::PH_B_ISSUE: begin
                bmean_next[k_reg] = mean_reg[k_reg];
                if (ok_reg) begin
                    ar_req.start = 1'b1;
                    ar_req.op    = vbam_pkg::OP_DIV;
                    ar_a         = m2_reg[k_reg];
                    ar_b         = {16'd0, count_reg};
                    ph_next      = vbam_pkg::PH_B_DWAIT;
                end else begin
                    spread_next[k_reg] = '0;
                    ph_next            = vbam_pkg::PH_B_NEXT;
                end
            end
            vbam_pkg::PH_B_DWAIT: begin
                if (ar_done) begin
                    ar_req.start = 1'b1;
                    ar_req.op    = vbam_pkg::OP_SQRT;
                    ar_a         = ar_res;
                    ph_next      = vbam_pkg::PH_B_SWAIT;
                end
            end
            vbam_pkg::PH_B_SWAIT: begin
                if (ar_done) begin
                    spread_next[k_reg] = qa[31:0];
                    if (qa[31:0] == 32'd0) begin
                        ok_next = 1'b0;
                    end
                    ph_next = vbam_pkg::PH_B_NEXT;
                end
            end
            vbam_pkg::PH_B_NEXT: begin
                if (k_reg == 2'd2) begin
                    ph_next = vbam_pkg::PH_B_END;
                end else begin
                    k_next  = k_reg + 2'd1;
                    ph_next = vbam_pkg::PH_B_ISSUE;
                end
            end
            vbam_pkg::PH_B_END: begin
                if (ok_reg) begin
                    bok_next  = 1'b1;
                    mode_next = vbam_pkg::MODE_HEALTHY;
                    ab_next   = '0;
                    no_next   = '0;
                end else begin
                    count_next  = '0;
                    mean_next   = '{default: '0};
                    m2_next     = '{default: '0};
                    bmean_next  = '{default: '0};
                    spread_next = '{default: '0};
                    bok_next    = 1'b0;
                    mode_next   = vbam_pkg::MODE_WARMUP;
                end
                ph_next = vbam_pkg::PH_M_END;
                k_next  = '0;
                ok_next = 1'b0;
            end
            vbam_pkg::PH_M_ISSUE: begin
                d33          = {1'b0, x_reg[k_reg]} - {1'b0, bmean_reg[k_reg]};
                sign_next    = d33[32];
                a_next       = d33[32] ? 32'(-d33) : d33[31:0];
                ar_req.start = 1'b1;
                ar_req.op    = vbam_pkg::OP_DIV;
                ar_a         = {16'd0, a_next, 16'd0};
                ar_b         = spread_reg[k_reg];
                mul_a        = bmean_reg[k_reg];
                mul_b        = {15'd0, 17'({1'b0, mean_margin_reg} + 17'h10000)};
                mul_next     = {32'd0, mul_a} * {32'd0, mul_b};
                ph_next      = vbam_pkg::PH_M_WAIT;
            end
            vbam_pkg::PH_M_WAIT: begin
                if (ar_done) begin
                    if (!sign_reg) begin
                        score_next[k_reg] = (qa > {40'd0, vbam_pkg::SCORE_MAX})
                                          ? vbam_pkg::SCORE_MAX : qa[23:0];
                    end else begin
                        score_next[k_reg] = (qa > {40'd0, vbam_pkg::SCORE_MIN})
                                          ? vbam_pkg::SCORE_MIN : 24'(-qa[23:0]);
                    end
                    flags_next[k_reg] = ov_mean && ov_z;
                    if (k_reg == 2'd2) begin
                        ph_next = vbam_pkg::PH_M_END;
                        // hysteresis runs on the next cycle with all three flags
                        k_next  = '0;
                        ok_next = 1'b1;
                    end else begin
                        k_next  = k_reg + 2'd1;
                        ph_next = vbam_pkg::PH_M_ISSUE;
                    end
                end
            end
            vbam_pkg::PH_M_END: begin
                if (ok_reg) begin
                    if (mode_reg == vbam_pkg::MODE_HEALTHY) begin
                        if (abn) begin
                            ab_next = ab_inc;
                            no_next = '0;
                            if (ab_inc >= alarm_run_reg) begin
                                mode_next = vbam_pkg::MODE_ALARM;
                                ab_next   = '0;
                                no_next   = '0;
                            end
                        end else begin
                            ab_next = '0;
                        end
                    end else if (mode_reg == vbam_pkg::MODE_ALARM) begin
                        if (abn) begin
                            no_next = '0;
                        end else begin
                            no_next = no_inc;
                            if (no_inc >= healthy_run_reg) begin
                                mode_next = vbam_pkg::MODE_HEALTHY;
                                no_next   = '0;
                                ab_next   = '0;
                            end
                        end
                    end
                end
                ok_next = 1'b0;
                if (!ok_reg || !m_valid_reg || m_ready) begin
                    // without a hysteresis step, publish once the output is free; otherwise next pass
                    if (!ok_reg) begin
                        out_load = !m_valid_reg || m_ready;
                        ph_next  = out_load ? vbam_pkg::PH_IDLE : vbam_pkg::PH_M_END;
                    end
                end
            end
            default: begin
                ph_next = vbam_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        out_next.machine_state   = mode_reg;
        out_next.warmup_progress = count_reg;
        out_next.rms_score       = score_reg[0];
        out_next.kurtosis_score  = score_reg[1];
        out_next.harmonic_score  = score_reg[2];
        out_next.rms_flag        = flags_reg[0];
        out_next.kurtosis_flag   = flags_reg[1];
        out_next.harmonic_flag   = flags_reg[2];
        m_valid_next = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warmup_target_reg <= vbam_pkg::RST_WARMUP_TARGET;
            min_valid_reg     <= vbam_pkg::RST_MIN_VALID;
            score_thresh_reg  <= vbam_pkg::RST_SCORE_THRESH;
            mean_margin_reg   <= vbam_pkg::RST_MEAN_MARGIN;
            alarm_run_reg     <= vbam_pkg::RST_ALARM_RUN;
            healthy_run_reg   <= vbam_pkg::RST_HEALTHY_RUN;
            silent_run_reg    <= vbam_pkg::RST_SILENT_RUN;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                vbam_pkg::CFG_WARMUP_TARGET: warmup_target_reg <= cfg_wdata[15:0];
                vbam_pkg::CFG_MIN_VALID:     min_valid_reg     <= cfg_wdata[15:0];
                vbam_pkg::CFG_SCORE_THRESH:  score_thresh_reg  <= cfg_wdata[22:0];
                vbam_pkg::CFG_MEAN_MARGIN:   mean_margin_reg   <= cfg_wdata[15:0];
                vbam_pkg::CFG_ALARM_RUN:     alarm_run_reg     <= cfg_wdata[7:0];
                vbam_pkg::CFG_HEALTHY_RUN:   healthy_run_reg   <= cfg_wdata[7:0];
                vbam_pkg::CFG_SILENT_RUN:    silent_run_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg  <= s_data.action;
            pv_reg   <= s_data.peak_seen;
            x_reg[0] <= s_data.rms_level;
            x_reg[1] <= s_data.kurtosis_level;
            x_reg[2] <= s_data.harmonic_amplitude;
        end
        sign_reg <= sign_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        mul_reg  <= mul_next;
        out_reg  <= out_load ? out_next : out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg      <= vbam_pkg::PH_IDLE;
            k_reg       <= '0;
            ok_reg      <= 1'b0;
            mode_reg    <= vbam_pkg::MODE_INIT;
            count_reg   <= '0;
            mean_reg    <= '{default: '0};
            m2_reg      <= '{default: '0};
            bmean_reg   <= '{default: '0};
            spread_reg  <= '{default: '0};
            bok_reg     <= 1'b0;
            ab_reg      <= '0;
            no_reg      <= '0;
            sil_reg     <= '0;
            score_reg   <= '{default: '0};
            flags_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ph_reg      <= ph_next;
            k_reg       <= k_next;
            ok_reg      <= ok_next;
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            mean_reg    <= mean_next;
            m2_reg      <= m2_next;
            bmean_reg   <= bmean_next;
            spread_reg  <= spread_next;
            bok_reg     <= bok_next;
            ab_reg      <= ab_next;
            no_reg      <= no_next;
            sil_reg     <= sil_next;
            score_reg   <= score_next;
            flags_reg   <= flags_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

### design/vbam_checker.sv
// Port-level checks for the vibration baseline anomaly monitor, bound to the
// top level. Depends on vbam_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "vibration_baseline_anomaly_monitor_defines.svh"

module vbam_checker (
    input wire                      aclk,
    input wire                      aresetn,
    input wire                      s_valid,
    input wire                      s_ready,
    input wire                      m_valid,
    input wire                      m_ready,
    input wire vbam_pkg::out_item_t m_data
);

    `VBAM_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")

    `VBAM_ASSERT_NXT(a_busy_after_req, aclk, aresetn, s_valid && s_ready, !s_ready, "request taken while busy")

    `VBAM_ASSERT_IMP(a_no_motor_clear, aclk, aresetn, m_valid && m_data.machine_state == 3'(vbam_pkg::MODE_NO_MOTOR), !m_data.rms_flag && !m_data.kurtosis_flag && !m_data.harmonic_flag && m_data.rms_score == 24'sd0 && m_data.kurtosis_score == 24'sd0 && m_data.harmonic_score == 24'sd0, "no-motor result carries scores")

    `VBAM_ASSERT_IMP(a_warmup_no_flags, aclk, aresetn, m_valid && (m_data.machine_state == 3'(vbam_pkg::MODE_INIT) || m_data.machine_state == 3'(vbam_pkg::MODE_WARMUP)), !m_data.rms_flag && !m_data.kurtosis_flag && !m_data.harmonic_flag, "flag raised before baseline")

endmodule

bind vibration_baseline_anomaly_monitor vbam_checker u_vbam_checker (.*);

`default_nettype wire
